// ===== rtl/wrl_pkg.sv =====
package wrl_pkg;

   // field widths
   localparam int AccelWidth  = 16;
   localparam int MinuteWidth = 11;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDatWidth = 11;

   // configuration register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_GESTURE_ENABLE      = 2'd0,
      CSR_WINDOW_START_MINUTE = 2'd1,
      CSR_WINDOW_END_MINUTE   = 2'd2
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic                   GESTURE_ENABLE_RESET = 1'b1;
   localparam logic [MinuteWidth-1:0] WINDOW_START_RESET   = 11'd0;
   localparam logic [MinuteWidth-1:0] WINDOW_END_RESET     = 11'd1439;

   // pose thresholds, milli-g
   localparam logic signed [AccelWidth-1:0] LOWER_Z_MIN     = -16'sd1000;
   localparam logic signed [AccelWidth-1:0] SIDE_Y_MIN      = 16'sd600;
   localparam logic signed [AccelWidth-1:0] LOWER_X_MAX     = -16'sd400;
   localparam logic signed [AccelWidth-1:0] LOWER_Z_FLAT    = 16'sd500;
   localparam logic signed [AccelWidth-1:0] LOWER_Z_CLEAR   = -16'sd1500;
   localparam logic signed [AccelWidth-1:0] POSE0_Z_MIN     = -16'sd200;
   localparam logic signed [AccelWidth-1:0] POSE1_Y_MAX     = 16'sd500;
   localparam logic signed [AccelWidth-1:0] POSE1_X_MAX     = -16'sd500;
   localparam logic signed [AccelWidth-1:0] POSE1_Z_MIN     = 16'sd200;
   localparam logic signed [AccelWidth-1:0] FACE_DOWN_Z_MAX = -16'sd500;
   localparam logic signed [AccelWidth-1:0] RAISE_Y_MAX     = 16'sd310;
   localparam logic signed [AccelWidth-1:0] RAISE_X_MIN     = -16'sd170;
   localparam logic signed [AccelWidth-1:0] RAISE_Z_MAX     = -16'sd300;

   // counter widths and limits
   localparam int LowerWidth = 4;
   localparam int ShortWidth = 3;
   localparam int RunWidth   = 5;
   localparam int IdleWidth  = 8;
   localparam int ShortPoses = 4;

   localparam logic [LowerWidth-1:0] LOWER_LIMIT = 4'd10;
   localparam logic [ShortWidth-1:0] SHORT_LIMIT = 3'd3;
   localparam logic [RunWidth-1:0]   RUN_LIMIT   = 5'd20;
   localparam logic [IdleWidth-1:0]  IDLE_MAX    = 8'd255;
   localparam logic [IdleWidth-1:0]  IDLE_WAKE   = 8'd60;

   // pose decisions for one sample
   typedef struct packed {
      logic lowered;
      logic lower_clear;
      logic pose0;
      logic pose1;
      logic pose2;
      logic pose3;
      logic face_down;
      logic raise;
   } pose_type;

   // one result beat
   typedef struct packed {
      logic screen_asleep;
      logic wake_event;
      logic sleep_event;
      logic sample_used;
      logic batch_done;
   } result_type;

endpackage

// ===== rtl/wrl_pose.sv =====
module wrl_pose
   import wrl_pkg::*;
(
   input  logic signed [AccelWidth-1:0] accel_x,
   input  logic signed [AccelWidth-1:0] accel_y,
   input  logic signed [AccelWidth-1:0] accel_z,
   output pose_type                     pose
);

   logic ay_gt_side;
   logic ay_lt_pose1;
   logic ay_lt_raise;

   // magnitude tests on y without forming |y|
   assign ay_gt_side  = (accel_y > SIDE_Y_MIN) || (accel_y < -SIDE_Y_MIN);
   assign ay_lt_pose1 = (accel_y < POSE1_Y_MAX) && (accel_y > -POSE1_Y_MAX);
   assign ay_lt_raise = (accel_y < RAISE_Y_MAX) && (accel_y > -RAISE_Y_MAX);

   // pose classes
   always_comb begin
      pose.lowered     = (accel_z > LOWER_Z_MIN) &&
                         (ay_gt_side || (accel_x < LOWER_X_MAX) || (accel_z > LOWER_Z_FLAT));
      pose.lower_clear = accel_z < LOWER_Z_CLEAR;
      pose.pose0       = ay_gt_side && (accel_z > POSE0_Z_MIN);
      pose.pose1       = ay_lt_pose1 && (accel_x < POSE1_X_MAX) && (accel_z > POSE1_Z_MIN);
      pose.pose2       = ay_gt_side && (accel_z < FACE_DOWN_Z_MAX);
      pose.pose3       = (accel_x < LOWER_X_MAX) && (accel_z < FACE_DOWN_Z_MAX);
      pose.face_down   = accel_z < FACE_DOWN_Z_MAX;
      pose.raise       = ay_lt_raise && (accel_x > RAISE_X_MIN) && (accel_z < RAISE_Z_MAX);
   end

endmodule

// ===== rtl/wrl_state.sv =====
module wrl_state
   import wrl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_wdata,
   input  logic                   commit,
   input  logic [MinuteWidth-1:0] minute_of_day,
   input  logic                   batch_last,
   input  pose_type               pose,
   output result_type             result
);

   logic                   gesture_enable_ff;
   logic [MinuteWidth-1:0] window_start_ff;
   logic [MinuteWidth-1:0] window_end_ff;

   logic                  asleep_ff,   asleep_in;
   logic [LowerWidth-1:0] lower_ff,    lower_in;
   logic [ShortWidth-1:0] short_ff [ShortPoses];
   logic [ShortWidth-1:0] short_in [ShortPoses];
   logic [RunWidth-1:0]   run_ff,      run_in;
   logic [IdleWidth-1:0]  idle_ff,     idle_in;

   logic used;
   logic wake;
   logic slept;
   logic short_hit;
   logic [1:0] short_sel;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gesture_enable_ff <= GESTURE_ENABLE_RESET;
         window_start_ff   <= WINDOW_START_RESET;
         window_end_ff     <= WINDOW_END_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_GESTURE_ENABLE:      gesture_enable_ff <= csr_wdata[0];
            CSR_WINDOW_START_MINUTE: window_start_ff   <= csr_wdata;
            CSR_WINDOW_END_MINUTE:   window_end_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign used = gesture_enable_ff && (minute_of_day >= window_start_ff) &&
                 (minute_of_day <= window_end_ff);

   // first matching short pose
   always_comb begin
      short_hit = 1'b1;
      short_sel = 2'd0;
      if (pose.pose0) begin
         short_sel = 2'd0;
      end else if (pose.pose1) begin
         short_sel = 2'd1;
      end else if (pose.pose2) begin
         short_sel = 2'd2;
      end else if (pose.pose3) begin
         short_sel = 2'd3;
      end else begin
         short_hit = 1'b0;
      end
   end

   // next state for one sample
   always_comb begin
      asleep_in = asleep_ff;
      lower_in  = lower_ff;
      run_in    = run_ff;
      idle_in   = idle_ff;
      for (int k = 0; k < ShortPoses; k++) begin
         short_in[k] = short_ff[k];
      end
      wake  = 1'b0;
      slept = 1'b0;

      if (used) begin
         // lower-wrist sleep
         if (asleep_ff) begin
            lower_in = '0;
         end else begin
            if (pose.lower_clear) begin
               lower_in = '0;
            end
            if ((lower_in != '0) && pose.lowered) begin
               if (lower_in > LOWER_LIMIT) begin
                  lower_in  = '0;
                  asleep_in = 1'b1;
                  slept     = 1'b1;
               end else begin
                  lower_in = lower_in + 1'b1;
               end
            end
         end

         // orientation classes
         if (short_hit) begin
            if (short_ff[short_sel] > SHORT_LIMIT) begin
               short_in[short_sel] = '0;
               idle_in             = '0;
            end else begin
               short_in[short_sel] = short_ff[short_sel] + 1'b1;
            end
         end else if (pose.face_down) begin
            if (run_ff > RUN_LIMIT) begin
               run_in  = '0;
               idle_in = '0;
            end else begin
               run_in = run_ff + 1'b1;
            end
         end else begin
            for (int k = 0; k < ShortPoses; k++) begin
               short_in[k] = '0;
            end
            run_in = '0;
            if (idle_ff != IDLE_MAX) begin
               idle_in = idle_ff + 1'b1;
            end
         end

         // raise wake, judged on the updated idle count
         if (pose.raise && (idle_in < IDLE_WAKE)) begin
            lower_in  = LowerWidth'(1);
            asleep_in = 1'b0;
            wake      = 1'b1;
         end
      end
   end

   // gesture state
   always_ff @(posedge clock) begin
      if (reset) begin
         asleep_ff <= 1'b0;
         lower_ff  <= '0;
         run_ff    <= '0;
         idle_ff   <= '0;
         for (int k = 0; k < ShortPoses; k++) begin
            short_ff[k] <= '0;
         end
      end else if (commit) begin
         asleep_ff <= asleep_in;
         lower_ff  <= lower_in;
         run_ff    <= run_in;
         idle_ff   <= idle_in;
         for (int k = 0; k < ShortPoses; k++) begin
            short_ff[k] <= short_in[k];
         end
      end
   end

   // result of this sample
   always_comb begin
      result.screen_asleep = asleep_in;
      result.wake_event    = wake;
      result.sleep_event   = slept;
      result.sample_used   = used;
      result.batch_done    = batch_last;
   end

endmodule

// ===== rtl/wrist_raise_lower_detector.sv =====
// Wrist raise / lower detector. Takes one accelerometer sample per beat and
// returns one result beat per sample, in order. A new sample can be taken in
// every cycle while the result side does not stall: the sample is registered,
// then all pose tests and counter update run combinationally into the result
// register, updating the gesture state once per sample. A result-side stall
// holds the result register, and the input register while full, and reaches
// the sample side in the same cycle. Configuration writes take effect at
// once; the user must make them while no sample is in flight (unchecked).
module wrist_raise_lower_detector
   import wrl_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [CsrIdxWidth-1:0]       csr_index,
   input  logic [CsrDatWidth-1:0]       csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [AccelWidth-1:0] req_accel_x,
   input  logic signed [AccelWidth-1:0] req_accel_y,
   input  logic signed [AccelWidth-1:0] req_accel_z,
   input  logic [MinuteWidth-1:0]       req_minute_of_day,
   input  logic                         req_batch_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_screen_asleep,
   output logic                         rsp_wake_event,
   output logic                         rsp_sleep_event,
   output logic                         rsp_sample_used,
   output logic                         rsp_batch_done
);

   logic                         s1_valid_ff, s1_valid_in;
   logic signed [AccelWidth-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [MinuteWidth-1:0]       s1_minute_ff;
   logic                         s1_last_ff;
   logic                         out_valid_ff, out_valid_in;
   result_type                   out_ff;

   logic       advance_out;
   logic       advance_in;
   logic       commit;
   pose_type   pose;
   result_type result;

   // pipeline flow
   assign advance_out  = !out_valid_ff || !rsp_stall;
   assign advance_in   = !s1_valid_ff || advance_out;
   assign commit       = s1_valid_ff && advance_out;
   assign req_stall    = !advance_in;
   assign s1_valid_in  = advance_in ? req_valid : s1_valid_ff;
   assign out_valid_in = advance_out ? s1_valid_ff : out_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (advance_in && req_valid) begin
         s1_x_ff      <= req_accel_x;
         s1_y_ff      <= req_accel_y;
         s1_z_ff      <= req_accel_z;
         s1_minute_ff <= req_minute_of_day;
         s1_last_ff   <= req_batch_last;
      end
   end

   wrl_pose u_pose (
      .accel_x (s1_x_ff),
      .accel_y (s1_y_ff),
      .accel_z (s1_z_ff),
      .pose    (pose)
   );

   wrl_state u_state (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .commit           (commit),
      .minute_of_day    (s1_minute_ff),
      .batch_last       (s1_last_ff),
      .pose             (pose),
      .result           (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (commit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_screen_asleep = out_ff.screen_asleep;
   assign rsp_wake_event    = out_ff.wake_event;
   assign rsp_sleep_event   = out_ff.sleep_event;
   assign rsp_sample_used   = out_ff.sample_used;
   assign rsp_batch_done    = out_ff.batch_done;

`ifndef ASSERT_OFF
   // a wake and a sleep cannot come from the same sample
   a_wake_sleep_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_wake_event && rsp_sleep_event))
      else $error("wake and sleep in one result");

   // an ignored sample raises no event
   a_ignored_no_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sample_used) |-> (!rsp_wake_event && !rsp_sleep_event))
      else $error("event on ignored sample");

   // events agree with the reported screen state
   a_event_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_sleep_event || rsp_screen_asleep) &&
                     (!rsp_wake_event || !rsp_screen_asleep)))
      else $error("event disagrees with screen state");

   // a held sample stays in the input register while the result side stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |=>
         (s1_valid_ff && $stable(s1_minute_ff) && $stable(s1_z_ff)))
      else $error("input register lost a held sample");
`endif

endmodule
